@@ rtl/data_pattern_generator_checker_assert.svh @@
// Assertion macros for the pattern engine RTL
`ifndef DATA_PATTERN_GENERATOR_CHECKER_ASSERT_SVH
`define DATA_PATTERN_GENERATOR_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define DPGC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pattern engine assertion failed");

// Next-cycle implication, disabled while reset is low
`define DPGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pattern engine assertion failed");

`endif

@@ rtl/dpgc_pkg.sv @@
package dpgc_pkg;

    // Pattern modes
    localparam logic [2:0] MODE_SEQUENTIAL  = 3'd0;
    localparam logic [2:0] MODE_ALTERNATING = 3'd1;
    localparam logic [2:0] MODE_PRIME       = 3'd2;
    localparam logic [2:0] MODE_LCG         = 3'd3;
    localparam logic [2:0] MODE_BLOCK       = 3'd4;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_PATTERN_MODE    = 3'd0;
    localparam logic [2:0] REG_OFFSET_OR_SEED  = 3'd1;
    localparam logic [2:0] REG_BLOCK_SIZE      = 3'd2;
    localparam logic [2:0] REG_START_BLOCK     = 3'd3;
    localparam logic [2:0] REG_CHECKSUM_ENABLE = 3'd4;
    localparam logic [2:0] REG_PAYLOAD_LENGTH  = 3'd5;

    localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] LCG_MUL       = 32'd1103515245;
    localparam logic [31:0] LCG_ADD       = 32'd12345;
    localparam logic [7:0]  ALT_EVEN      = 8'hAA;
    localparam logic [7:0]  ALT_ODD       = 8'h55;
    localparam logic [3:0]  PRIME_LAST    = 4'd11;
    localparam logic [15:0] MIN_BLOCK     = 16'd4;

    typedef enum logic [1:0] {
        KIND_PATTERN  = 2'd0,
        KIND_TRAILER  = 2'd1,
        KIND_PAST_END = 2'd2
    } t_kind;

    // Generator state that advances only on pattern bytes
    typedef struct packed {
        logic [31:0] lcg;
        logic [31:0] block_number;
        logic [15:0] byte_in_block;
        logic [3:0]  prime_index;
    } t_gen_state;

    // Twelve-entry prime cycle; out-of-range index falls back to the first
    function automatic logic [7:0] prime_value(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'd2;
            4'd1:    v = 8'd3;
            4'd2:    v = 8'd5;
            4'd3:    v = 8'd7;
            4'd4:    v = 8'd11;
            4'd5:    v = 8'd13;
            4'd6:    v = 8'd17;
            4'd7:    v = 8'd19;
            4'd8:    v = 8'd23;
            4'd9:    v = 8'd29;
            4'd10:   v = 8'd31;
            4'd11:   v = 8'd37;
            default: v = 8'd2;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/data_pattern_generator_checker.sv @@
// Byte pattern generator and checker. Each input item either requests the next
// pattern byte (op 0) or checks a received byte against it (op 1); one result
// item comes back for every input item, in order. An item is taken in every
// clock cycle when the output side keeps up; each item passes through the
// input register, then the result register, and the sustained rate of one
// item per cycle is set by the combinational update of the generator, CRC and
// position state, which includes the 32x32 LCG multiply and a byte of CRC-32.
// Registers on the APB port should be written only while no item is in flight.
module data_pattern_generator_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_tuser,   // [0] op, [1] first
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // [7:0] value, [8] mismatch, [9] mismatch_seen,
                                     // [41:10] position, [73:42] crc, [79:74] zero
    output logic [1:0]  o_m_tuser,   // [1:0] byte_kind
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration registers
    logic [2:0]  r_mode;
    logic [31:0] r_offset;
    logic [15:0] r_block_size;
    logic [31:0] r_start_block;
    logic        r_cs_en;
    logic [31:0] r_payload_len;
    logic [2:0]  reg_idx;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 3'd0;
            r_offset      <= 32'd0;
            r_block_size  <= 16'd512;
            r_start_block <= 32'd0;
            r_cs_en       <= 1'b0;
            r_payload_len <= 32'd512;
        end else if (cfg_write) begin
            case (reg_idx)
                dpgc_pkg::REG_PATTERN_MODE:    r_mode        <= pwdata[2:0];
                dpgc_pkg::REG_OFFSET_OR_SEED:  r_offset      <= pwdata;
                dpgc_pkg::REG_BLOCK_SIZE:      r_block_size  <= pwdata[15:0];
                dpgc_pkg::REG_START_BLOCK:     r_start_block <= pwdata;
                dpgc_pkg::REG_CHECKSUM_ENABLE: r_cs_en       <= pwdata[0];
                dpgc_pkg::REG_PAYLOAD_LENGTH:  r_payload_len <= pwdata;
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            dpgc_pkg::REG_PATTERN_MODE:    prdata = {29'd0, r_mode};
            dpgc_pkg::REG_OFFSET_OR_SEED:  prdata = r_offset;
            dpgc_pkg::REG_BLOCK_SIZE:      prdata = {16'd0, r_block_size};
            dpgc_pkg::REG_START_BLOCK:     prdata = r_start_block;
            dpgc_pkg::REG_CHECKSUM_ENABLE: prdata = {31'd0, r_cs_en};
            dpgc_pkg::REG_PAYLOAD_LENGTH:  prdata = r_payload_len;
            default:                       prdata = 32'd0;
        endcase
    end

    // Input register and handshake
    logic       r_in_valid;
    logic       r_in_op;
    logic       r_in_first;
    logic [7:0] r_in_data;
    logic       r_out_valid;
    logic       advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_op    <= i_s_tuser[0];
            r_in_first <= i_s_tuser[1];
            r_in_data  <= i_s_tdata;
        end
    end

    // Running state
    dpgc_pkg::t_gen_state r_gen;
    logic [31:0]          r_pos;
    logic [31:0]          r_crc;
    logic                 r_sticky;

    // Current state, with a first item restarting everything
    dpgc_pkg::t_gen_state cur_gen;
    logic [31:0]          cur_pos;
    logic [31:0]          cur_crc;
    logic                 cur_sticky;

    always_comb begin
        if (r_in_first) begin
            cur_gen.lcg           = r_offset;
            cur_gen.block_number  = r_start_block;
            cur_gen.byte_in_block = 16'd0;
            cur_gen.prime_index   = 4'd0;
            cur_pos               = 32'd0;
            cur_crc               = dpgc_pkg::CRC_ALL_ONES;
            cur_sticky            = 1'b0;
        end else begin
            cur_gen    = r_gen;
            cur_pos    = r_pos;
            cur_crc    = r_crc;
            cur_sticky = r_sticky;
        end
    end

    dpgc_pkg::t_gen_state gen_next;
    logic [7:0]           pat_value;
    logic [31:0]          crc_next;

    dpgc_pattern u_pattern (
        .i_mode       (r_mode),
        .i_offset     (r_offset),
        .i_block_size (r_block_size),
        .i_pos        (cur_pos),
        .i_state      (cur_gen),
        .o_value      (pat_value),
        .o_state      (gen_next)
    );

    dpgc_crc u_crc (
        .i_crc  (cur_crc),
        .i_byte (pat_value),
        .o_crc  (crc_next)
    );

    // Classify the position: payload, CRC trailer or past end
    logic              is_pattern;
    logic [31:0]       trail_ofs;
    dpgc_pkg::t_kind   kind;
    logic [31:0]       crc_final_cur;
    logic [7:0]        value;
    logic [31:0]       crc_upd;
    logic              mism;

    assign is_pattern    = !r_cs_en || (cur_pos < r_payload_len);
    assign trail_ofs     = cur_pos - r_payload_len;
    assign crc_final_cur = ~cur_crc;

    always_comb begin
        if (is_pattern) begin
            kind  = dpgc_pkg::KIND_PATTERN;
            value = pat_value;
        end else if (trail_ofs[31:2] == 30'd0) begin
            kind = dpgc_pkg::KIND_TRAILER;
            case (trail_ofs[1:0])
                2'd0:    value = crc_final_cur[7:0];
                2'd1:    value = crc_final_cur[15:8];
                2'd2:    value = crc_final_cur[23:16];
                2'd3:    value = crc_final_cur[31:24];
                default: value = 8'd0;
            endcase
        end else begin
            kind  = dpgc_pkg::KIND_PAST_END;
            value = 8'd0;
        end
    end

    assign crc_upd = is_pattern ? crc_next : cur_crc;
    assign mism    = (kind != dpgc_pkg::KIND_PAST_END) && r_in_op && (r_in_data != value);

    // State update, once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen    <= '0;
            r_pos    <= 32'd0;
            r_crc    <= dpgc_pkg::CRC_ALL_ONES;
            r_sticky <= 1'b0;
        end else if (advance) begin
            r_gen    <= is_pattern ? gen_next : cur_gen;
            r_pos    <= (cur_pos == 32'hFFFF_FFFF) ? cur_pos : cur_pos + 32'd1;
            r_crc    <= crc_upd;
            r_sticky <= cur_sticky | mism;
        end
    end

    // Result register
    logic [7:0]      r_out_value;
    dpgc_pkg::t_kind r_out_kind;
    logic            r_out_mism;
    logic            r_out_seen;
    logic [31:0]     r_out_pos;
    logic [31:0]     r_out_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_value <= value;
            r_out_kind  <= kind;
            r_out_mism  <= mism;
            r_out_seen  <= cur_sticky | mism;
            r_out_pos   <= cur_pos;
            r_out_crc   <= ~crc_upd;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_crc, r_out_pos, r_out_seen, r_out_mism, r_out_value};
    assign o_m_tuser  = r_out_kind;

    // Checks
    logic out_past_end;
    logic out_quiet;

    assign out_past_end = o_m_tvalid && (o_m_tuser == dpgc_pkg::KIND_PAST_END);
    assign out_quiet    = (o_m_tdata[7:0] == 8'd0) && !o_m_tdata[8];

`include "data_pattern_generator_checker_assert.svh"

    `DPGC_ASSERT_NOW(a_past_end_quiet, i_clk, i_rst_n, out_past_end, out_quiet)
    `DPGC_ASSERT_NOW(a_mismatch_sticky, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[8], o_m_tdata[9])
    `DPGC_ASSERT_NEXT(a_advance_shows, i_clk, i_rst_n, advance, o_m_tvalid)

endmodule

@@ rtl/dpgc_crc.sv @@
// One byte of reflected CRC-32, bit at a time over eight steps
module dpgc_crc (
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ dpgc_pkg::CRC_POLY) : (c >> 1);
        end
        o_crc = c;
    end

endmodule

@@ rtl/dpgc_pattern.sv @@
// Next pattern byte and the generator state after it
module dpgc_pattern (
    input  logic [2:0]            i_mode,
    input  logic [31:0]           i_offset,
    input  logic [15:0]           i_block_size,
    input  logic [31:0]           i_pos,
    input  dpgc_pkg::t_gen_state  i_state,
    output logic [7:0]            o_value,
    output dpgc_pkg::t_gen_state  o_state
);

    logic [15:0] block_size_eff;
    logic [16:0] bib_inc;
    logic [31:0] lcg_next;
    logic [7:0]  block_value;

    assign block_size_eff = (i_block_size < dpgc_pkg::MIN_BLOCK) ? dpgc_pkg::MIN_BLOCK
                                                                  : i_block_size;
    assign bib_inc  = {1'b0, i_state.byte_in_block} + 17'd1;
    assign lcg_next = i_state.lcg * dpgc_pkg::LCG_MUL + dpgc_pkg::LCG_ADD;

    // Block header holds the block number little endian
    always_comb begin
        if (i_state.byte_in_block < 16'd4) begin
            case (i_state.byte_in_block[1:0])
                2'd0:    block_value = i_state.block_number[7:0];
                2'd1:    block_value = i_state.block_number[15:8];
                2'd2:    block_value = i_state.block_number[23:16];
                2'd3:    block_value = i_state.block_number[31:24];
                default: block_value = 8'd0;
            endcase
        end else begin
            block_value = i_state.block_number[7:0] + i_state.byte_in_block[7:0];
        end
    end

    always_comb begin
        o_state = i_state;
        o_value = 8'd0;
        case (i_mode)
            dpgc_pkg::MODE_SEQUENTIAL: begin
                o_value = i_offset[7:0] + i_pos[7:0];
            end
            dpgc_pkg::MODE_ALTERNATING: begin
                o_value = i_pos[0] ? dpgc_pkg::ALT_ODD : dpgc_pkg::ALT_EVEN;
            end
            dpgc_pkg::MODE_PRIME: begin
                o_value = dpgc_pkg::prime_value(i_state.prime_index);
                o_state.prime_index = (i_state.prime_index >= dpgc_pkg::PRIME_LAST) ? 4'd0
                                      : i_state.prime_index + 4'd1;
            end
            dpgc_pkg::MODE_LCG: begin
                o_value     = lcg_next[23:16];
                o_state.lcg = lcg_next;
            end
            dpgc_pkg::MODE_BLOCK: begin
                o_value = block_value;
                if (bib_inc >= {1'b0, block_size_eff}) begin
                    o_state.byte_in_block = 16'd0;
                    o_state.block_number  = i_state.block_number + 32'd1;
                end else begin
                    o_state.byte_in_block = bib_inc[15:0];
                end
            end
            default: begin
                o_value = 8'd0;
            end
        endcase
    end

endmodule

@@ verif/dpgc_result_checker.sv @@
`timescale 1ns / 100ps

// Scoreboard for the pattern engine: mirrors the register writes, predicts one
// result item per accepted input item and compares the result stream in order.
module dpgc_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream as seen on the wire
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [1:0]  i_s_tuser,   // [0] op, [1] first
    // Result stream as seen on the wire
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,   // [7:0] value, [8] mismatch, [9] mismatch_seen,
                                     // [41:10] position, [73:42] crc, [79:74] zero
    input  logic [1:0]  i_m_tuser,   // [1:0] byte_kind
    // Register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    // Status to the testbench top
    output int          o_pending,
    output int          o_fail_count,
    output int          o_checked
);

    localparam logic [95:0] PRIME_TABLE = {8'd37, 8'd31, 8'd29, 8'd23, 8'd19, 8'd17,
                                           8'd13, 8'd11, 8'd7,  8'd5,  8'd3,  8'd2};

    typedef struct packed {
        logic [7:0]      value;
        dpgc_pkg::t_kind kind;
        logic            mism;
        logic            seen;
        logic [31:0]     pos;
        logic [31:0]     crc;
    } t_byte_result;

    // Mirrored registers
    logic [2:0]  cfg_mode;
    logic [31:0] cfg_seed;
    logic [15:0] cfg_bsize;
    logic [31:0] cfg_sblock;
    logic        cfg_csum;
    logic [31:0] cfg_plen;

    // Predicted engine state
    logic [31:0] pos_q;
    logic [31:0] lcg_q;
    logic [31:0] blk_q;
    logic [15:0] bib_q;
    logic [3:0]  prime_q;
    logic [31:0] crc_q;
    logic        sticky_q;

    t_byte_result expected_bytes [$];
    int fail_cnt;
    int checked_cnt;

    // One byte of reflected CRC-32
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        int k;
        c = crc_in ^ {24'd0, b};
        for (k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ dpgc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Next pattern byte; advances the generator of the current mode
    task automatic advance_generator(output logic [7:0] v);
        logic [15:0] bs;
        v = 8'h00;
        case (cfg_mode)
            dpgc_pkg::MODE_SEQUENTIAL: begin
                v = cfg_seed[7:0] + pos_q[7:0];
            end
            dpgc_pkg::MODE_ALTERNATING: begin
                v = pos_q[0] ? dpgc_pkg::ALT_ODD : dpgc_pkg::ALT_EVEN;
            end
            dpgc_pkg::MODE_PRIME: begin
                v = PRIME_TABLE[8*prime_q +: 8];
                prime_q = (prime_q >= dpgc_pkg::PRIME_LAST) ? 4'd0 : prime_q + 4'd1;
            end
            dpgc_pkg::MODE_LCG: begin
                lcg_q = lcg_q * dpgc_pkg::LCG_MUL + dpgc_pkg::LCG_ADD;
                v = lcg_q[23:16];
            end
            dpgc_pkg::MODE_BLOCK: begin
                bs = (cfg_bsize < dpgc_pkg::MIN_BLOCK) ? dpgc_pkg::MIN_BLOCK : cfg_bsize;
                // header carries the block number little endian
                if (bib_q < dpgc_pkg::MIN_BLOCK) begin
                    v = blk_q[8*bib_q[1:0] +: 8];
                end else begin
                    v = blk_q[7:0] + bib_q[7:0];
                end
                if ({1'b0, bib_q} + 17'd1 >= {1'b0, bs}) begin
                    bib_q = 16'd0;
                    blk_q = blk_q + 32'd1;
                end else begin
                    bib_q = bib_q + 16'd1;
                end
            end
            default: v = 8'h00;
        endcase
    endtask

    // Expected result of one accepted item
    task automatic predict_item(input logic is_check, input logic restart,
                                input logic [7:0] rx_byte);
        t_byte_result r;
        logic [7:0]  v;
        logic [31:0] fin;
        logic [31:0] tail;
        if (restart) begin
            pos_q    = 32'd0;
            lcg_q    = cfg_seed;
            blk_q    = cfg_sblock;
            bib_q    = 16'd0;
            prime_q  = 4'd0;
            crc_q    = dpgc_pkg::CRC_ALL_ONES;
            sticky_q = 1'b0;
        end
        v = 8'h00;
        r.kind = dpgc_pkg::KIND_PATTERN;
        if (!cfg_csum || pos_q < cfg_plen) begin
            advance_generator(v);
            crc_q = crc32_byte(crc_q, v);
        end else if ({1'b0, pos_q} < {1'b0, cfg_plen} + 33'd4) begin
            // trailer: finalized crc, low byte first
            r.kind = dpgc_pkg::KIND_TRAILER;
            fin  = crc_q ^ dpgc_pkg::CRC_ALL_ONES;
            tail = pos_q - cfg_plen;
            v    = fin[8*tail[1:0] +: 8];
        end else begin
            r.kind = dpgc_pkg::KIND_PAST_END;
        end
        r.value  = v;
        r.mism   = (r.kind != dpgc_pkg::KIND_PAST_END) && is_check && (rx_byte != v);
        sticky_q = sticky_q | r.mism;
        r.seen   = sticky_q;
        r.pos    = pos_q;
        r.crc    = crc_q ^ dpgc_pkg::CRC_ALL_ONES;
        if (pos_q != 32'hFFFF_FFFF) begin
            pos_q = pos_q + 32'd1;
        end
        expected_bytes.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_cnt++;
        end
    endtask

    // Watch all three ports at every edge
    always @(posedge i_clk) begin
        t_byte_result got;
        t_byte_result want;
        if (!i_rst_n) begin
            cfg_mode   = dpgc_pkg::MODE_SEQUENTIAL;
            cfg_seed   = 32'd0;
            cfg_bsize  = 16'd512;
            cfg_sblock = 32'd0;
            cfg_csum   = 1'b0;
            cfg_plen   = 32'd512;
            pos_q      = 32'd0;
            lcg_q      = 32'd0;
            blk_q      = 32'd0;
            bib_q      = 16'd0;
            prime_q    = 4'd0;
            crc_q      = dpgc_pkg::CRC_ALL_ONES;
            sticky_q   = 1'b0;
            expected_bytes.delete();
            fail_cnt    = 0;
            checked_cnt = 0;
        end else begin
            // register writes take effect at once
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    dpgc_pkg::REG_PATTERN_MODE:    cfg_mode   = i_pwdata[2:0];
                    dpgc_pkg::REG_OFFSET_OR_SEED:  cfg_seed   = i_pwdata;
                    dpgc_pkg::REG_BLOCK_SIZE:      cfg_bsize  = i_pwdata[15:0];
                    dpgc_pkg::REG_START_BLOCK:     cfg_sblock = i_pwdata;
                    dpgc_pkg::REG_CHECKSUM_ENABLE: cfg_csum   = i_pwdata[0];
                    dpgc_pkg::REG_PAYLOAD_LENGTH:  cfg_plen   = i_pwdata;
                    default: ;
                endcase
            end
            // result side first: a result never belongs to the item taken this edge
            if (i_m_tvalid && i_m_tready) begin
                got.value = i_m_tdata[7:0];
                got.mism  = i_m_tdata[8];
                got.seen  = i_m_tdata[9];
                got.pos   = i_m_tdata[41:10];
                got.crc   = i_m_tdata[73:42];
                got.kind  = dpgc_pkg::t_kind'(i_m_tuser);
                checked_cnt++;
                if (expected_bytes.size() == 0) begin
                    $display("%0t: result item with none expected, expected none, actual %h",
                             $time, i_m_tdata);
                    fail_cnt++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("value", {24'd0, want.value}, {24'd0, got.value});
                    check_field("byte_kind", {30'd0, want.kind}, {30'd0, got.kind});
                    check_field("mismatch", {31'd0, want.mism}, {31'd0, got.mism});
                    check_field("mismatch_seen", {31'd0, want.seen}, {31'd0, got.seen});
                    check_field("position", want.pos, got.pos);
                    check_field("crc", want.crc, got.crc);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_item(i_s_tuser[0], i_s_tuser[1], i_s_tdata);
            end
        end
        o_pending    <= expected_bytes.size();
        o_fail_count <= fail_cnt;
        o_checked    <= checked_cnt;
    end

endmodule

@@ verif/data_pattern_generator_checker_tb.sv @@
`timescale 1ns / 100ps

module data_pattern_generator_checker_tb;

    localparam logic       OP_GEN        = 1'b0;
    localparam logic       OP_CHECK      = 1'b1;
    localparam logic [2:0] MODE_UNUSED   = 3'd7;
    localparam logic [2:0] REG_UNUSED_6  = 3'd6;
    localparam logic [2:0] REG_UNUSED_7  = 3'd7;
    localparam int         ITEM_TARGET   = 1950;
    localparam int         WATCHDOG_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = 8'h00;
    logic [1:0]  i_s_tuser  = 2'b00;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [79:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [4:0]  paddr      = 5'd0;
    logic [31:0] pwdata     = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int n_pending;
    int n_fail;
    int n_checked;

    int burst_left  = 0;
    int items_sent  = 0;
    int phases      = 0;
    int idle_cycles = 0;
    logic [7:0] rx_cycle = 8'd0;
    logic [1:0] rx_style = 2'd0;
    logic [7:0] captured_bytes [$];

    // Current register setting, used to size the runs
    logic        cur_csum;
    logic [31:0] cur_plen;

    data_pattern_generator_checker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    dpgc_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (n_pending),
        .o_fail_count (n_fail),
        .o_checked    (n_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: picks a new random stall style each time its 8-bit cycle counter wraps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            rx_cycle   <= 8'd0;
            rx_style   <= 2'd0;
        end else begin
            rx_cycle <= rx_cycle + 8'd1;
            if (rx_cycle == 8'd0) begin
                rx_style <= 2'($urandom_range(0, 3));
            end
            case (rx_style)
                2'd0:    i_m_tready <= 1'b1;
                2'd1:    i_m_tready <= ($urandom_range(0, 3) != 0);
                2'd2:    i_m_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_tready <= (rx_cycle[3:0] >= 4'd5);
            endcase
        end
    end

    // Keep generated bytes so they can be played back as received data
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            captured_bytes.push_back(o_m_tdata[7:0]);
        end
    end

    // Watchdog on cycles without any accepted item or register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding", $time, n_pending);
                $display("data_pattern_generator_checker_tb NOT OK");
                $finish;
            end
        end
    end

    // Setup and access phase of one register write, then the bus returns to idle
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // One item; the sender may pause between bursts of random length
    task automatic send_item(input logic op, input logic restart, input logic [7:0] data);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tuser  <= {restart, op};
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        items_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (n_pending != 0);
    endtask

    task automatic random_setup();
        int unsigned r;
        logic [2:0]  mode;
        logic [31:0] seed;
        logic [15:0] bsize;
        logic [31:0] sblock;
        r = $urandom_range(0, 15);
        // unused modes 5..7 now and then
        mode = (r < 13) ? 3'(r % 5) : 3'(r - 8);
        case ($urandom_range(0, 3))
            0:       seed = 32'd0;
            1:       seed = 32'hFFFF_FFFF;
            default: seed = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       bsize = 16'($urandom_range(0, 3));
            6:       bsize = 16'hFFFF;
            7:       bsize = 16'($urandom_range(4, 65535));
            default: bsize = 16'($urandom_range(4, 24));
        endcase
        case ($urandom_range(0, 3))
            0:       sblock = 32'd0;
            1:       sblock = 32'hFFFF_FFFF;
            2:       sblock = 32'hFFFF_FFFE;
            default: sblock = $urandom;
        endcase
        cur_csum = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       cur_plen = 32'd0;
            1:       cur_plen = 32'hFFFF_FFFF;
            2:       cur_plen = $urandom;
            default: cur_plen = $urandom_range(1, 48);
        endcase
        apb_write(dpgc_pkg::REG_PATTERN_MODE, {29'd0, mode});
        apb_write(dpgc_pkg::REG_OFFSET_OR_SEED, seed);
        apb_write(dpgc_pkg::REG_BLOCK_SIZE, {16'd0, bsize});
        apb_write(dpgc_pkg::REG_START_BLOCK, sblock);
        apb_write(dpgc_pkg::REG_CHECKSUM_ENABLE, {31'd0, cur_csum});
        apb_write(dpgc_pkg::REG_PAYLOAD_LENGTH, cur_plen);
        phases++;
    endtask

    initial begin
        logic [7:0]  readback [$];
        logic [7:0]  rx;
        int unsigned run_len;
        int          i;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting, no first item; unused register slots are ignored
        apb_write(REG_UNUSED_6, 32'hFFFF_FFFF);
        apb_write(REG_UNUSED_7, 32'hFFFF_FFFF);
        send_item(OP_GEN, 1'b0, 8'hFF);
        send_item(OP_GEN, 1'b0, 8'h00);
        send_item(OP_CHECK, 1'b0, 8'h02);
        send_item(OP_CHECK, 1'b0, 8'h00);
        send_item(OP_GEN, 1'b1, 8'hFF);
        drain();
        phases++;

        // Alternating with a short payload: trailer, then past end
        apb_write(dpgc_pkg::REG_PATTERN_MODE, {29'd0, dpgc_pkg::MODE_ALTERNATING});
        apb_write(dpgc_pkg::REG_CHECKSUM_ENABLE, 32'd1);
        apb_write(dpgc_pkg::REG_PAYLOAD_LENGTH, 32'd3);
        send_item(OP_GEN, 1'b1, 8'h00);
        send_item(OP_CHECK, 1'b0, 8'h55);
        send_item(OP_GEN, 1'b0, 8'h00);
        send_item(OP_CHECK, 1'b0, 8'h00);
        for (i = 0; i < 3; i++) send_item(OP_GEN, 1'b0, 8'h00);
        send_item(OP_CHECK, 1'b0, 8'hFF);
        drain();
        phases++;

        // Zero payload: the trailer opens the buffer
        apb_write(dpgc_pkg::REG_PATTERN_MODE, {29'd0, dpgc_pkg::MODE_PRIME});
        apb_write(dpgc_pkg::REG_PAYLOAD_LENGTH, 32'd0);
        send_item(OP_GEN, 1'b1, 8'h00);
        for (i = 0; i < 4; i++) send_item(OP_CHECK, 1'b0, 8'h00);
        drain();
        phases++;

        // Unused mode and a block size below the minimum
        apb_write(dpgc_pkg::REG_PATTERN_MODE, {29'd0, MODE_UNUSED});
        apb_write(dpgc_pkg::REG_CHECKSUM_ENABLE, 32'd0);
        apb_write(dpgc_pkg::REG_BLOCK_SIZE, 32'd0);
        send_item(OP_CHECK, 1'b1, 8'h00);
        send_item(OP_GEN, 1'b0, 8'hFF);
        drain();
        phases++;

        // Block mode with the block number wrapping past all ones
        apb_write(dpgc_pkg::REG_PATTERN_MODE, {29'd0, dpgc_pkg::MODE_BLOCK});
        apb_write(dpgc_pkg::REG_BLOCK_SIZE, 32'd1);
        apb_write(dpgc_pkg::REG_START_BLOCK, 32'hFFFF_FFFF);
        for (i = 0; i < 8; i++) send_item(OP_GEN, i == 0, 8'($urandom));
        drain();
        phases++;

        // Random setups: mostly generate then read back, some noise
        while (items_sent < ITEM_TARGET) begin
            random_setup();
            if (cur_csum && cur_plen <= 32'd48) begin
                run_len = cur_plen + $urandom_range(1, 8);
            end else begin
                run_len = $urandom_range(1, 60);
            end
            if ($urandom_range(0, 9) < 7) begin
                captured_bytes.delete();
                for (i = 0; i < run_len; i++) send_item(OP_GEN, i == 0, 8'($urandom));
                drain();
                readback = captured_bytes;
                captured_bytes.delete();
                // play back with an occasional corrupted byte
                for (i = 0; i < readback.size(); i++) begin
                    rx = readback[i];
                    if ($urandom_range(0, 19) == 0) begin
                        rx = rx ^ 8'($urandom_range(1, 255));
                    end
                    send_item(OP_CHECK, i == 0, rx);
                end
            end else begin
                for (i = 0; i < run_len; i++) begin
                    send_item(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0,
                              8'($urandom));
                end
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        $display("Run covered %0d input items over %0d register setups, %0d results compared",
                 items_sent, phases, n_checked);
        if (n_fail == 0 && n_pending == 0) begin
            $display("data_pattern_generator_checker_tb OK");
        end else begin
            $display("data_pattern_generator_checker_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dpgc_pkg.sv
rtl/dpgc_crc.sv
rtl/dpgc_pattern.sv
rtl/data_pattern_generator_checker.sv
verif/dpgc_result_checker.sv
verif/data_pattern_generator_checker_tb.sv
